### sv/mvbs_pkg.sv
// mvbs_pkg: shared types, codes and defaults for the masked volume box statistics block
// no dependencies; imported by mvbs_ctrl, mvbs_datapath and masked_volume_box_statistics_top

package mvbs_pkg;

    // default sizing
    localparam int DEF_MAX_DIM     = 16;
    localparam int DEF_NUM_VOLUMES = 4;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 48;
    localparam int CFG_W    = 5;
    localparam int CFG_IW   = 3;

    // request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // statistic codes
    localparam logic [2:0] STAT_COUNT = 3'd0;
    localparam logic [2:0] STAT_SUM   = 3'd1;
    localparam logic [2:0] STAT_SUMSQ = 3'd2;
    localparam logic [2:0] STAT_MIN   = 3'd3;
    localparam logic [2:0] STAT_MAX   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_DIM_X   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_DIM_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DIM_Z   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SIGNED  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_PRESENT = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic       wr_en;
        logic       issue;
        logic       clear;
        logic       finish;
        logic       bad;
        logic       mask_en;
        logic       val_signed;
        logic [2:0] kind;
    } mvbs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic busy;
        logic out_full;
    } mvbs_sts_t;

endpackage

### sv/mvbs_ctrl.sv
// mvbs_ctrl: configuration registers, request decode, query state machine and box walker
// depends on mvbs_pkg; drives mvbs_datapath through mvbs_cmd_t and memory addresses

module mvbs_ctrl #(
    parameter int MAX_DIM     = mvbs_pkg::DEF_MAX_DIM,
    parameter int NUM_VOLUMES = mvbs_pkg::DEF_NUM_VOLUMES,
    parameter int MEM_AW      = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mvbs_pkg::CFG_IW-1:0] cfg_index,
    input  logic [mvbs_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [1:0]                  load_volume,
    input  logic [11:0]                 voxel_index,
    input  logic [1:0]                  value_volume,
    input  logic                        mask_enable,
    input  logic [1:0]                  mask_volume,
    input  logic [2:0]                  stat_kind,
    input  logic signed [7:0]           box_x,
    input  logic signed [7:0]           box_y,
    input  logic signed [7:0]           box_z,
    input  mvbs_pkg::mvbs_sts_t         sts,
    output mvbs_pkg::mvbs_cmd_t         cmd,
    output logic [MEM_AW-1:0]           wr_addr,
    output logic [MEM_AW-1:0]           rd_addr_v,
    output logic [MEM_AW-1:0]           rd_addr_m
);
    import mvbs_pkg::*;

    localparam int VOL_SIZE = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW       = (VOL_SIZE > 1) ? $clog2(VOL_SIZE) : 1;
    localparam int DW       = $clog2(MAX_DIM + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RANGE  = 3'd1;
    localparam logic [2:0] S_BASE   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [4:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic [3:0] signed_reg, present_reg;

    logic              q_mask_en_reg;
    logic [1:0]        q_vvol_reg, q_mvol_reg;
    logic [2:0]        q_kind_reg;
    logic signed [7:0] q_bx_reg, q_by_reg, q_bz_reg;
    logic              bad_reg, bad_next;

    logic [DW-1:0]   xl_reg, xh_reg, yl_reg, yh_reg, zl_reg, zh_reg;
    logic [DW-1:0]   xl_next, xh_next, yl_next, yh_next, zl_next, zh_next;
    logic [DW-1:0]   dx_reg, dx_next;
    logic [2*DW-1:0] dxy_reg, dxy_next;
    logic [DW-1:0]   x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [AW-1:0]   addr_reg, addr_next, row_reg, row_next, plane_reg, plane_next;

    logic accept;
    logic x_last, y_last, z_last;
    logic [DW-1:0] dy_eff, dz_eff;

    // clamp a dimension register to the usable range
    function automatic logic [DW-1:0] eff_dim(input logic [4:0] d);
        if (d == 5'd0)
            return DW'(1);
        else if (32'(d) > MAX_DIM)
            return DW'(MAX_DIM);
        else
            return DW'(d);
    endfunction

    // one box coordinate to a half-open index range
    function automatic void axis_range(input logic signed [7:0] c, input logic [DW-1:0] dim,
                                       output logic [DW-1:0] lo, output logic [DW-1:0] hi);
        int ci;
        ci = int'(c);
        if (ci < -1)
            ci = 0;
        if (ci >= int'(dim))
            ci = int'(dim) - 1;
        if (ci == -1)
        begin
            lo = '0;
            hi = dim;
        end
        else
        begin
            lo = DW'(ci);
            hi = DW'(ci + 1);
        end
    endfunction

    function automatic logic vol_ok(input logic [1:0] v, input logic [3:0] present);
        return (32'(v) < NUM_VOLUMES) && present[v];
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg   <= 5'd16;
            dim_y_reg   <= 5'd16;
            dim_z_reg   <= 5'd16;
            signed_reg  <= '0;
            present_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIM_X:   dim_x_reg   <= cfg_data;
                CFG_DIM_Y:   dim_y_reg   <= cfg_data;
                CFG_DIM_Z:   dim_z_reg   <= cfg_data;
                CFG_SIGNED:  signed_reg  <= cfg_data[3:0];
                CFG_PRESENT: present_reg <= cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // query capture
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_QUERY)
        begin
            q_mask_en_reg <= mask_enable;
            q_vvol_reg    <= value_volume;
            q_mvol_reg    <= mask_volume;
            q_kind_reg    <= stat_kind;
            q_bx_reg      <= box_x;
            q_by_reg      <= box_y;
            q_bz_reg      <= box_z;
        end
    end

    assign dy_eff = eff_dim(dim_y_reg);
    assign dz_eff = eff_dim(dim_z_reg);
    assign x_last = (x_reg == xh_reg - DW'(1));
    assign y_last = (y_reg == yh_reg - DW'(1));
    assign z_last = (z_reg == zh_reg - DW'(1));

    // next state, walker and commands
    always_comb
    begin
        state_next = state_reg;
        bad_next   = bad_reg;
        xl_next    = xl_reg;
        xh_next    = xh_reg;
        yl_next    = yl_reg;
        yh_next    = yh_reg;
        zl_next    = zl_reg;
        zh_next    = zh_reg;
        dx_next    = dx_reg;
        dxy_next   = dxy_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        // load write and query context
        cmd.wr_en      = accept && (req_type == REQ_LOAD) && (32'(load_volume) < NUM_VOLUMES)
                         && (32'(voxel_index) < VOL_SIZE);
        cmd.bad        = bad_reg;
        cmd.mask_en    = q_mask_en_reg;
        cmd.val_signed = signed_reg[q_vvol_reg];
        cmd.kind       = q_kind_reg;
        cmd.issue  = 1'b0;
        cmd.clear  = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == REQ_QUERY)
                    state_next = S_RANGE;
            end
            S_RANGE:
            begin
                cmd.clear = 1'b1;
                dx_next   = eff_dim(dim_x_reg);
                dxy_next  = (2*DW)'(32'(eff_dim(dim_x_reg)) * 32'(dy_eff));
                axis_range(q_bx_reg, eff_dim(dim_x_reg), xl_next, xh_next);
                axis_range(q_by_reg, dy_eff, yl_next, yh_next);
                axis_range(q_bz_reg, dz_eff, zl_next, zh_next);
                bad_next = !vol_ok(q_vvol_reg, present_reg)
                        || (q_mask_en_reg && !vol_ok(q_mvol_reg, present_reg))
                        || (q_kind_reg > STAT_MAX);
                state_next = bad_next ? S_FINISH : S_BASE;
            end
            S_BASE:
            begin
                plane_next = AW'(32'(zl_reg) * 32'(dxy_reg) + 32'(yl_reg) * 32'(dx_reg)
                             + 32'(xl_reg));
                row_next   = plane_next;
                addr_next  = plane_next;
                x_next     = xl_reg;
                y_next     = yl_reg;
                z_next     = zl_reg;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.issue = 1'b1;
                if (!x_last)
                begin
                    x_next    = x_reg + DW'(1);
                    addr_next = addr_reg + AW'(1);
                end
                else if (!y_last)
                begin
                    x_next    = xl_reg;
                    y_next    = y_reg + DW'(1);
                    row_next  = row_reg + AW'(dx_reg);
                    addr_next = row_reg + AW'(dx_reg);
                end
                else if (!z_last)
                begin
                    x_next     = xl_reg;
                    y_next     = yl_reg;
                    z_next     = z_reg + DW'(1);
                    plane_next = plane_reg + AW'(dxy_reg);
                    row_next   = plane_reg + AW'(dxy_reg);
                    addr_next  = plane_reg + AW'(dxy_reg);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.busy)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // walker registers
    always_ff @(posedge clk)
    begin
        bad_reg   <= bad_next;
        xl_reg    <= xl_next;
        xh_reg    <= xh_next;
        yl_reg    <= yl_next;
        yh_reg    <= yh_next;
        zl_reg    <= zl_next;
        zh_reg    <= zh_next;
        dx_reg    <= dx_next;
        dxy_reg   <= dxy_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        addr_reg  <= addr_next;
        row_reg   <= row_next;
        plane_reg <= plane_next;
    end

    assign wr_addr   = MEM_AW'(32'(load_volume) * VOL_SIZE + 32'(voxel_index));
    assign rd_addr_v = MEM_AW'(32'(q_vvol_reg) * VOL_SIZE + 32'(addr_reg));
    assign rd_addr_m = MEM_AW'(32'(q_mvol_reg) * VOL_SIZE + 32'(addr_reg));

endmodule

### sv/mvbs_datapath.sv
// mvbs_datapath: sample memory, read and square pipeline, accumulators and result register
// depends on mvbs_pkg; commanded by mvbs_ctrl

module mvbs_datapath #(
    parameter int MAX_DIM     = mvbs_pkg::DEF_MAX_DIM,
    parameter int NUM_VOLUMES = mvbs_pkg::DEF_NUM_VOLUMES,
    parameter int MEM_AW      = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mvbs_pkg::mvbs_cmd_t               cmd,
    input  logic [MEM_AW-1:0]                 wr_addr,
    input  logic [mvbs_pkg::SAMPLE_W-1:0]     wr_data,
    input  logic [MEM_AW-1:0]                 rd_addr_v,
    input  logic [MEM_AW-1:0]                 rd_addr_m,
    output mvbs_pkg::mvbs_sts_t               sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mvbs_pkg::OUT_W-1:0] stat_value,
    output logic                              ok,
    output logic                              empty_res
);
    import mvbs_pkg::*;

    localparam int VOL_SIZE  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int MEM_DEPTH = NUM_VOLUMES * VOL_SIZE;
    localparam int CNT_W     = $clog2(VOL_SIZE + 1);
    localparam int SUM_W     = SAMPLE_W + 1 + CNT_W;
    localparam int SQ_W      = 32 + CNT_W;
    localparam logic signed [63:0] OUT_MAX64 = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN64 = -64'sh8000_0000_0000;

    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] vrd_reg, mrd_reg;
    logic                v1_reg, v2_reg;

    logic signed [SAMPLE_W:0]   t_val;
    logic signed [2*SAMPLE_W+1:0] t_prod;
    logic signed [SAMPLE_W:0]   t_reg, best_reg;
    logic [31:0]                sq_reg;
    logic                       have_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sumsq_reg;
    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    stat_value_reg, res_val;
    logic                       ok_reg, empty_reg, res_empty;
    logic signed [63:0]         sum64;
    logic [63:0]                sq64;
    logic                       take_best;

    // sample memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        vrd_reg <= mem[rd_addr_v];
        mrd_reg <= mem[rd_addr_m];
    end

    // sample interpretation and square
    assign t_val  = (cmd.val_signed && vrd_reg[SAMPLE_W-1]) ? $signed({1'b1, vrd_reg})
                                                            : $signed({1'b0, vrd_reg});
    assign t_prod = t_val * t_val;

    always_ff @(posedge clk)
    begin
        t_reg  <= t_val;
        sq_reg <= t_prod[31:0];
    end

    // pipeline valid bits; stage two only carries selected voxels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg && (!cmd.mask_en || mrd_reg != '0);
        end
    end

    assign take_best = !have_reg || (cmd.kind == STAT_MIN && t_reg < best_reg)
                       || (cmd.kind == STAT_MAX && t_reg > best_reg);

    // accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            have_reg  <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            best_reg  <= '0;
        end
        else if (v2_reg)
        begin
            have_reg  <= 1'b1;
            count_reg <= count_reg + CNT_W'(1);
            sum_reg   <= sum_reg + SUM_W'(t_reg);
            sumsq_reg <= sumsq_reg + SQ_W'(sq_reg);
            if (take_best)
                best_reg <= t_reg;
        end
    end

    // result selection, with saturation of the sum and the sum of squares
    assign sum64 = 64'(sum_reg);
    assign sq64  = 64'(sumsq_reg);

    always_comb
    begin
        res_val   = '0;
        res_empty = 1'b0;
        case (cmd.kind)
            STAT_COUNT:
                res_val = OUT_W'(count_reg);
            STAT_SUM:
            begin
                if (sum64 > OUT_MAX64)
                    res_val = OUT_MAX64[OUT_W-1:0];
                else if (sum64 < OUT_MIN64)
                    res_val = OUT_MIN64[OUT_W-1:0];
                else
                    res_val = sum64[OUT_W-1:0];
            end
            STAT_SUMSQ:
            begin
                if (sq64 > 64'(OUT_MAX64))
                    res_val = OUT_MAX64[OUT_W-1:0];
                else
                    res_val = sq64[OUT_W-1:0];
            end
            STAT_MIN, STAT_MAX:
            begin
                if (have_reg)
                    res_val = {{(OUT_W-SAMPLE_W-1){best_reg[SAMPLE_W]}}, best_reg};
                else
                    res_empty = 1'b1;
            end
            default:
                res_val = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            stat_value_reg <= cmd.bad ? '0 : res_val;
            ok_reg         <= !cmd.bad;
            empty_reg      <= !cmd.bad && res_empty;
        end
    end

    assign out_valid    = out_valid_reg;
    assign stat_value   = stat_value_reg;
    assign ok           = ok_reg;
    assign empty_res    = empty_reg;
    assign sts.busy     = v1_reg || v2_reg;
    assign sts.out_full = out_valid_reg && !out_ready;

endmodule

### sv/masked_volume_box_statistics_top.sv
// masked_volume_box_statistics_top: top level joining controller and datapath
// depends on mvbs_pkg, mvbs_ctrl and mvbs_datapath
//
//   channel   signals                        direction
//   in        in_valid / in_ready + fields   request transfer (load or query)
//   out       out_valid / out_ready + fields result transfer (one per query)
//   cfg       cfg_we, cfg_index, cfg_data    register write, no wait
//
// a load takes its accept cycle only (one memory write); a query is accepted, then passes
// the range and base setup states, walks the box one voxel per cycle (one read pair on the
// sample memory), waits for the pipeline to drain and then loads the result register; an
// invalid query goes from the range setup state straight to loading the result register.
// reset clears control state only; sample memory is undefined until written, no clearing pass.
// a stalled result waits in the output register while new loads are taken; a query that
// finishes while the previous result is still held waits for it to transfer.

module masked_volume_box_statistics_top #(
    parameter int MAX_DIM     = mvbs_pkg::DEF_MAX_DIM,
    parameter int NUM_VOLUMES = mvbs_pkg::DEF_NUM_VOLUMES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mvbs_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [mvbs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [1:0]                        load_volume,
    input  logic [11:0]                       voxel_index,
    input  logic [15:0]                       sample,
    input  logic [1:0]                        value_volume,
    input  logic                              mask_enable,
    input  logic [1:0]                        mask_volume,
    input  logic [2:0]                        stat_kind,
    input  logic signed [7:0]                 box_x,
    input  logic signed [7:0]                 box_y,
    input  logic signed [7:0]                 box_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mvbs_pkg::OUT_W-1:0] stat_value,
    output logic                              ok,
    output logic                              empty_res
);
    import mvbs_pkg::*;

    localparam int VOL_SIZE  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int MEM_DEPTH = NUM_VOLUMES * VOL_SIZE;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    mvbs_cmd_t         cmd;
    mvbs_sts_t         sts;
    logic [MEM_AW-1:0] wr_addr, rd_addr_v, rd_addr_m;

    // control
    mvbs_ctrl #(
        .MAX_DIM     (MAX_DIM),
        .NUM_VOLUMES (NUM_VOLUMES),
        .MEM_AW      (MEM_AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .load_volume  (load_volume),
        .voxel_index  (voxel_index),
        .value_volume (value_volume),
        .mask_enable  (mask_enable),
        .mask_volume  (mask_volume),
        .stat_kind    (stat_kind),
        .box_x        (box_x),
        .box_y        (box_y),
        .box_z        (box_z),
        .sts          (sts),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr_v    (rd_addr_v),
        .rd_addr_m    (rd_addr_m)
    );

    // datapath
    mvbs_datapath #(
        .MAX_DIM     (MAX_DIM),
        .NUM_VOLUMES (NUM_VOLUMES),
        .MEM_AW      (MEM_AW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .wr_data    (sample),
        .rd_addr_v  (rd_addr_v),
        .rd_addr_m  (rd_addr_m),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .stat_value (stat_value),
        .ok         (ok),
        .empty_res  (empty_res)
    );

endmodule
